/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define AST_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed through reset");

`endif

/* hdl/mbtrs_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus TCP register server package
// Constants, codes and the result layout shared by the server and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mbtrs_pkg;

    // Default size of the holding register file.
    localparam int NUM_REGS_DEFAULT = 1024;

    // Stream widths: fields packed from bit 0, padded to whole bytes.
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 112;
    localparam int REPLY_W   = 108;

    // Function codes served.
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_READ_INPUT   = 8'h04;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    // Request limits.
    localparam logic [15:0] READ_COUNT_LIMIT = 16'd127;
    localparam logic [15:0] FRAME_LEN_MIN    = 16'd3;

    // Reply lengths.
    localparam logic [7:0] LEN_WRITE_REPLY = 8'd6;
    localparam logic [7:0] LEN_EXC_REPLY   = 8'd3;
    localparam logic [7:0] LEN_READ_BASE   = 8'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_NORMAL    = 2'd0;
    localparam logic [1:0] STATUS_EXCEPTION = 2'd1;
    localparam logic [1:0] STATUS_DROPPED   = 2'd2;

    // Exception codes.
    localparam logic [1:0] EXC_ILLEGAL_FUNCTION = 2'd0;
    localparam logic [1:0] EXC_ILLEGAL_ADDRESS  = 2'd1;
    localparam logic [1:0] EXC_ILLEGAL_VALUE    = 2'd2;
    localparam logic [1:0] EXC_DEVICE_FAILURE   = 2'd3;

    // Multi-write run exception: zero means none, else exception code plus one.
    localparam logic [2:0] RUN_EXC_NONE = 3'd0;

    // One result item without its last flag; status sits in the lowest bits.
    typedef struct packed {
        logic [15:0] read_word_b;
        logic [15:0] read_word_a;
        logic [15:0] echo_second;
        logic [15:0] echo_first;
        logic [7:0]  reply_function;
        logic [7:0]  reply_unit;
        logic [7:0]  reply_length;
        logic [15:0] reply_transaction;
        logic [1:0]  exception_code;
        logic [1:0]  status;
    } reply_t;

endpackage

`default_nettype wire

/* hdl/modbus_tcp_register_server_unit.sv */
// ----------------------------------------------------------------------------
// Modbus TCP register server
// Serves decoded Modbus TCP requests against a 16-bit holding register file.
// ----------------------------------------------------------------------------
// After reset the block clears its register file, one entry per cycle, so it
// takes no request until the clearing pass is done. A dropped frame, an
// exception, a single write and each item of a multi-write run are handled in
// the cycle that takes them, and one request per cycle is taken while results
// are drained. A read of n registers gives max(1, ceil(n/2)) results: each
// register pair is fetched through the two read ports of the register file
// into the read data registers (ST_RD_ISSUE) and moves into the output register
// once it is free (ST_RD_DATA), and no new request is taken until the last
// result of the read has been loaded. Results leave through one output register.
`default_nettype none

module modbus_tcp_register_server_unit #(
    parameter int NUM_REGS = mbtrs_pkg::NUM_REGS_DEFAULT
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // Request channel.
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // transaction_id[15:0], protocol_id[31:16], length_field[47:32],
    // unit_id[55:48], function_code[63:56], start_address[79:64],
    // count_or_value[95:80], byte_count[103:96], data_word[119:104].
    input  wire  [mbtrs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire                             s_tlast,  // last_item
    // Result channel.
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // status[1:0], exception_code[3:2], reply_transaction[19:4],
    // reply_length[27:20], reply_unit[35:28], reply_function[43:36],
    // echo_first[59:44], echo_second[75:60], read_word_a[91:76],
    // read_word_b[107:92], zero padding[111:108].
    output logic [mbtrs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast   // last_result
);

    localparam int AddrW = $clog2(NUM_REGS);
    localparam logic [16:0] NumRegsW = 17'(NUM_REGS);
    localparam logic [AddrW-1:0] ClearLast = AddrW'(NUM_REGS - 1);

    localparam logic [1:0] ST_CLEAR    = 2'd0;
    localparam logic [1:0] ST_IDLE     = 2'd1;
    localparam logic [1:0] ST_RD_ISSUE = 2'd2;
    localparam logic [1:0] ST_RD_DATA  = 2'd3;

    // Builds an exception result.
    function automatic mbtrs_pkg::reply_t exc_reply(input logic [1:0] code,
                                                    input logic [15:0] tr,
                                                    input logic [7:0] unit,
                                                    input logic [7:0] fn);
        mbtrs_pkg::reply_t r;
        r = '0;
        r.status            = mbtrs_pkg::STATUS_EXCEPTION;
        r.exception_code    = code;
        r.reply_transaction = tr;
        r.reply_length      = mbtrs_pkg::LEN_EXC_REPLY;
        r.reply_unit        = unit;
        r.reply_function    = fn;
        return r;
    endfunction

    // Register file, read data and sequencing state.
    logic [15:0]       holding_mem [NUM_REGS];
    logic [15:0]       rd_a_reg, rd_b_reg;
    logic [1:0]        state_reg, state_next;
    logic [AddrW-1:0]  clr_cnt_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;
    mbtrs_pkg::reply_t out_reg, out_next;

    // Multi-write run state.
    logic              run_active_reg;
    logic [15:0]       saved_tr_reg, saved_start_reg, saved_count_reg, wp_reg;
    logic [7:0]        saved_unit_reg;
    logic [2:0]        run_exc_reg;

    // Read request state.
    logic [15:0]       rd_base_reg, rd_tr_reg;
    logic [6:0]        rd_count_reg;
    logic [5:0]        rd_pair_reg, rd_pair_next, rd_last_pair_reg;
    logic [7:0]        rd_unit_reg, rd_fn_reg;

    // Request fields.
    logic [15:0] in_tr, in_pid, in_len, in_start, in_cov, in_data;
    logic [7:0]  in_unit, in_fn, in_bc;

    assign in_tr    = s_tdata[15:0];
    assign in_pid   = s_tdata[31:16];
    assign in_len   = s_tdata[47:32];
    assign in_unit  = s_tdata[55:48];
    assign in_fn    = s_tdata[63:56];
    assign in_start = s_tdata[79:64];
    assign in_cov   = s_tdata[95:80];
    assign in_bc    = s_tdata[103:96];
    assign in_data  = s_tdata[119:104];

    // Handshake.
    logic s_accept, out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(mbtrs_pkg::M_TDATA_W - mbtrs_pkg::REPLY_W)'(0), out_reg};

    // Request decode.
    logic        frame_ok, is_read, span_bad, start_bad, read_ok, single_ok;
    logic [16:0] start_plus_cov;

    assign frame_ok = (in_pid == 16'd0) && (in_len >= mbtrs_pkg::FRAME_LEN_MIN)
                      && (in_len[15:8] == 8'd0);
    assign is_read  = (in_fn == mbtrs_pkg::FC_READ_HOLDING)
                      || (in_fn == mbtrs_pkg::FC_READ_INPUT);
    assign start_plus_cov = {1'b0, in_start} + {1'b0, in_cov};
    assign span_bad  = start_plus_cov > NumRegsW;
    assign start_bad = {1'b0, in_start} >= NumRegsW;
    assign read_ok   = !run_active_reg && frame_ok && is_read
                       && (in_cov < mbtrs_pkg::READ_COUNT_LIMIT) && !span_bad;
    assign single_ok = !run_active_reg && frame_ok
                       && (in_fn == mbtrs_pkg::FC_WRITE_SINGLE) && !start_bad;

    // Multi-write run: the opening item and later items share one path.
    logic        opening, in_run, bc_bad, run_wr;
    logic [2:0]  open_exc, cur_exc;
    logic [15:0] cur_start, cur_count, cur_wp, cur_tr, wp_next;
    logic [16:0] run_addr_sum;
    logic [7:0]  cur_unit;

    assign opening  = !run_active_reg && frame_ok && (in_fn == mbtrs_pkg::FC_WRITE_MULTI);
    assign in_run   = run_active_reg || opening;
    assign bc_bad   = {9'd0, in_bc} != {in_cov, 1'b0};

    always_comb begin
        if (bc_bad) begin
            open_exc = {1'b0, mbtrs_pkg::EXC_DEVICE_FAILURE} + 3'd1;
        end else if (span_bad) begin
            open_exc = {1'b0, mbtrs_pkg::EXC_ILLEGAL_ADDRESS} + 3'd1;
        end else begin
            open_exc = mbtrs_pkg::RUN_EXC_NONE;
        end
    end

    assign cur_exc   = run_active_reg ? run_exc_reg     : open_exc;
    assign cur_start = run_active_reg ? saved_start_reg : in_start;
    assign cur_count = run_active_reg ? saved_count_reg : in_cov;
    assign cur_wp    = run_active_reg ? wp_reg          : 16'd0;
    assign cur_tr    = run_active_reg ? saved_tr_reg    : in_tr;
    assign cur_unit  = run_active_reg ? saved_unit_reg  : in_unit;

    assign run_wr       = (cur_exc == mbtrs_pkg::RUN_EXC_NONE) && (cur_wp < cur_count);
    assign wp_next      = cur_wp + {15'd0, run_wr};
    assign run_addr_sum = {1'b0, cur_start} + {1'b0, cur_wp};

    // Register file write port: clearing pass, single write or run word.
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic [15:0]      mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = in_start[AddrW-1:0];
        mem_wdata = in_cov;
        if (s_accept && in_run && run_wr) begin
            mem_we    = 1'b1;
            mem_waddr = run_addr_sum[AddrW-1:0];
            mem_wdata = in_data;
        end else if (s_accept && single_ok) begin
            mem_we = 1'b1;
        end
    end

    // Read addresses of the current register pair.
    logic [6:0]       idx_a, idx_b;
    logic             a_used, b_used, rd_en;
    logic [16:0]      addr_a_sum, addr_b_sum;
    logic [AddrW-1:0] rd_addr_a, rd_addr_b;

    assign idx_a      = {rd_pair_reg, 1'b0};
    assign idx_b      = {rd_pair_reg, 1'b1};
    assign a_used     = idx_a < rd_count_reg;
    assign b_used     = idx_b < rd_count_reg;
    assign addr_a_sum = {1'b0, rd_base_reg} + {10'd0, idx_a};
    assign addr_b_sum = {1'b0, rd_base_reg} + {10'd0, idx_b};
    assign rd_addr_a  = addr_a_sum[AddrW-1:0];
    // Past the end of an odd count the second port repeats the first address.
    assign rd_addr_b  = b_used ? addr_b_sum[AddrW-1:0] : addr_a_sum[AddrW-1:0];
    assign rd_en      = state_reg == ST_RD_ISSUE;

    // Register file: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            holding_mem[clr_cnt_reg] <= 16'd0;
        end else if (mem_we) begin
            holding_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_a_reg <= holding_mem[rd_addr_a];
            rd_b_reg <= holding_mem[rd_addr_b];
        end
    end

    // Result of a request answered on the cycle it is taken.
    logic              imm_valid;
    mbtrs_pkg::reply_t imm_reply, run_reply, read_reply;

    always_comb begin
        run_reply = '0;
        if (cur_exc != mbtrs_pkg::RUN_EXC_NONE) begin
            run_reply = exc_reply(2'(cur_exc - 3'd1), cur_tr, cur_unit,
                                  mbtrs_pkg::FC_WRITE_MULTI);
        end else if (wp_next < cur_count) begin
            run_reply = exc_reply(mbtrs_pkg::EXC_ILLEGAL_VALUE, cur_tr, cur_unit,
                                  mbtrs_pkg::FC_WRITE_MULTI);
        end else begin
            run_reply.status            = mbtrs_pkg::STATUS_NORMAL;
            run_reply.reply_transaction = cur_tr;
            run_reply.reply_length      = mbtrs_pkg::LEN_WRITE_REPLY;
            run_reply.reply_unit        = cur_unit;
            run_reply.reply_function    = mbtrs_pkg::FC_WRITE_MULTI;
            run_reply.echo_first        = cur_start;
            run_reply.echo_second       = cur_count;
        end
    end

    always_comb begin
        imm_valid = 1'b1;
        imm_reply = '0;
        priority if (in_run) begin
            imm_valid = s_tlast;
            imm_reply = run_reply;
        end else if (!frame_ok) begin
            imm_reply.status            = mbtrs_pkg::STATUS_DROPPED;
            imm_reply.reply_transaction = in_tr;
            imm_reply.reply_unit        = in_unit;
            imm_reply.reply_function    = in_fn;
        end else if (is_read) begin
            if (in_cov >= mbtrs_pkg::READ_COUNT_LIMIT) begin
                imm_reply = exc_reply(mbtrs_pkg::EXC_ILLEGAL_VALUE, in_tr, in_unit, in_fn);
            end else if (span_bad) begin
                imm_reply = exc_reply(mbtrs_pkg::EXC_ILLEGAL_ADDRESS, in_tr, in_unit, in_fn);
            end else begin
                imm_valid = 1'b0;
            end
        end else if (in_fn == mbtrs_pkg::FC_WRITE_SINGLE) begin
            if (start_bad) begin
                imm_reply = exc_reply(mbtrs_pkg::EXC_ILLEGAL_ADDRESS, in_tr, in_unit, in_fn);
            end else begin
                imm_reply.status            = mbtrs_pkg::STATUS_NORMAL;
                imm_reply.reply_transaction = in_tr;
                imm_reply.reply_length      = mbtrs_pkg::LEN_WRITE_REPLY;
                imm_reply.reply_unit        = in_unit;
                imm_reply.reply_function    = in_fn;
                imm_reply.echo_first        = in_start;
                imm_reply.echo_second       = in_cov;
            end
        end else begin
            imm_reply = exc_reply(mbtrs_pkg::EXC_ILLEGAL_FUNCTION, in_tr, in_unit, in_fn);
        end
    end

    // Read result from the fetched register pair.
    always_comb begin
        read_reply                   = '0;
        read_reply.status            = mbtrs_pkg::STATUS_NORMAL;
        read_reply.reply_transaction = rd_tr_reg;
        read_reply.reply_length      = mbtrs_pkg::LEN_READ_BASE + {rd_count_reg, 1'b0};
        read_reply.reply_unit        = rd_unit_reg;
        read_reply.reply_function    = rd_fn_reg;
        read_reply.echo_first        = {8'd0, rd_count_reg, 1'b0};
        read_reply.read_word_a       = a_used ? rd_a_reg : 16'd0;
        read_reply.read_word_b       = b_used ? rd_b_reg : 16'd0;
    end

    // Sequencer and output register next values.
    always_comb begin
        state_next     = state_reg;
        rd_pair_next   = rd_pair_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        out_next       = out_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == ClearLast) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept && imm_valid) begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_next       = imm_reply;
                end
                if (s_accept && read_ok) begin
                    state_next   = ST_RD_ISSUE;
                    rd_pair_next = 6'd0;
                end
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = rd_pair_reg == rd_last_pair_reg;
                    out_next       = read_reply;
                    rd_pair_next   = rd_pair_reg + 6'd1;
                    state_next     = (rd_pair_reg == rd_last_pair_reg) ? ST_IDLE
                                                                       : ST_RD_ISSUE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Last pair index of a read of count_or_value registers.
    logic [6:0] cov_n, cov_n_minus;

    assign cov_n       = in_cov[6:0];
    assign cov_n_minus = cov_n - 7'd1;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            run_active_reg  <= 1'b0;
            saved_tr_reg    <= 16'd0;
            saved_unit_reg  <= 8'd0;
            saved_start_reg <= 16'd0;
            saved_count_reg <= 16'd0;
            wp_reg          <= 16'd0;
            run_exc_reg     <= mbtrs_pkg::RUN_EXC_NONE;
            rd_pair_reg     <= 6'd0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_pair_reg   <= rd_pair_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AddrW'(1);
            end
            if (s_accept && in_run) begin
                run_active_reg <= !s_tlast;
                wp_reg         <= wp_next;
                run_exc_reg    <= cur_exc;
            end
            if (s_accept && opening) begin
                saved_tr_reg    <= in_tr;
                saved_unit_reg  <= in_unit;
                saved_start_reg <= in_start;
                saved_count_reg <= in_cov;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (s_accept && read_ok) begin
            rd_base_reg      <= in_start;
            rd_count_reg     <= cov_n;
            rd_last_pair_reg <= (cov_n == 7'd0) ? 6'd0 : cov_n_minus[6:1];
            rd_tr_reg        <= in_tr;
            rd_unit_reg      <= in_unit;
            rd_fn_reg        <= in_fn;
        end
    end

endmodule

`default_nettype wire

/* hdl/mbtrs_port_checker.sv */
// ----------------------------------------------------------------------------
// Modbus TCP register server port checker
// Watches the server's ports for reset, stall and result-shape slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mbtrs_port_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tready,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [mbtrs_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire                             m_tlast
);

    // Result fields and handshake states that the checks look at.
    logic       m_stalled, m_exc, m_drop;
    logic [7:0] m_length;

    assign m_stalled = m_tvalid && !m_tready;
    assign m_exc     = m_tvalid && (m_tdata[1:0] == mbtrs_pkg::STATUS_EXCEPTION);
    assign m_drop    = m_tvalid && (m_tdata[1:0] == mbtrs_pkg::STATUS_DROPPED);
    assign m_length  = m_tdata[27:20];

    // Reset empties the output register.
    `AST_NEXT_ALWAYS(a_reset_empties, aclk, !aresetn, !m_tvalid)

    // The register file clearing pass keeps requests out right after reset.
    `AST_IMPLY(a_no_request_in_clear, aclk, aresetn, $rose(aresetn), !s_tready)

    // A stalled result holds.
    `AST_NEXT(a_stall_holds, aclk, aresetn, m_stalled, m_tvalid && $stable({m_tlast, m_tdata}))

    // Exceptions and dropped frames are single results of fixed length.
    `AST_IMPLY(a_exc_shape, aclk, aresetn, m_exc, m_tlast && m_length == mbtrs_pkg::LEN_EXC_REPLY)
    `AST_IMPLY(a_drop_shape, aclk, aresetn, m_drop, m_tlast && m_length == 8'd0)

endmodule

bind modbus_tcp_register_server_unit mbtrs_port_checker u_port_checker (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Modbus TCP register server testbench
// Drives decoded requests into the server with random pacing on both sides,
// predicts every reply from a private copy of the holding register file and
// compares each reply field by field as it leaves the block.
// ----------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mbtrs_pkg::*;

    localparam int NUM_REGS       = NUM_REGS_DEFAULT;
    localparam int RANDOM_ITEMS   = 380;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 12;

    localparam logic [15:0] FRAME_LEN_MAX = 16'd255;
    localparam logic [7:0]  LEN_DROPPED   = 8'd0;
    localparam logic [1:0]  EXC_NONE      = 2'd0;
    localparam logic [7:0]  FC_LOWEST     = 8'h00;
    localparam logic [7:0]  FC_HIGHEST    = 8'hFF;

    // One request as it travels on s_tdata, first field in the lowest bits.
    typedef struct packed {
        logic [15:0] data_word;
        logic [7:0]  byte_count;
        logic [15:0] count_or_value;
        logic [15:0] start_address;
        logic [7:0]  function_code;
        logic [7:0]  unit_id;
        logic [15:0] length_field;
        logic [15:0] protocol_id;
        logic [15:0] transaction_id;
    } request_t;

    // One awaited reply together with its last flag.
    typedef struct {
        reply_t body;
        logic   last;
    } awaited_reply_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Private copy of the server state.
    logic [15:0] holding_regs [NUM_REGS];
    logic        run_open;
    logic [15:0] run_transaction;
    logic [7:0]  run_unit;
    logic [15:0] run_start;
    logic [15:0] run_count;
    logic [15:0] run_words;
    logic [2:0]  run_fault;

    awaited_reply_t awaited_replies [$];

    int  error_count   = 0;
    int  requests_sent = 0;
    int  quiet_cycles  = 0;
    bit  sender_pauses = 1'b1;
    bit  sink_pauses   = 1'b1;

    modbus_tcp_register_server_unit #(
        .NUM_REGS(NUM_REGS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Reply prediction
    // ------------------------------------------------------------------------

    task automatic push_reply(input logic [1:0] st, input logic [1:0] exc,
                              input logic [15:0] tr, input logic [7:0] len,
                              input logic [7:0] unit, input logic [7:0] fn,
                              input logic [15:0] first, input logic [15:0] second,
                              input logic [15:0] wa, input logic [15:0] wb,
                              input logic last);
        awaited_reply_t x;
        x.body.status            = st;
        x.body.exception_code    = exc;
        x.body.reply_transaction = tr;
        x.body.reply_length      = len;
        x.body.reply_unit        = unit;
        x.body.reply_function    = fn;
        x.body.echo_first        = first;
        x.body.echo_second       = second;
        x.body.read_word_a       = wa;
        x.body.read_word_b       = wb;
        x.last                   = last;
        awaited_replies.push_back(x);
    endtask

    task automatic push_exception(input logic [1:0] exc, input logic [15:0] tr,
                                  input logic [7:0] unit, input logic [7:0] fn);
        push_reply(STATUS_EXCEPTION, exc, tr, LEN_EXC_REPLY, unit, fn,
                   '0, '0, '0, '0, 1'b1);
    endtask

    // One data item of an open multi-write run.
    task automatic absorb_run_word(input logic [15:0] word, input logic last);
        int unsigned addr;
        if (run_fault == RUN_EXC_NONE && run_words < run_count) begin
            addr = int'(run_start) + int'(run_words);
            if (addr < NUM_REGS)
                holding_regs[addr] = word;
            run_words++;
        end
        if (!last)
            return;
        run_open = 1'b0;
        if (run_fault != RUN_EXC_NONE)
            push_exception(2'(run_fault - 3'd1), run_transaction, run_unit,
                           FC_WRITE_MULTI);
        else if (run_words < run_count)
            push_exception(EXC_ILLEGAL_VALUE, run_transaction, run_unit,
                           FC_WRITE_MULTI);
        else
            push_reply(STATUS_NORMAL, EXC_NONE, run_transaction, LEN_WRITE_REPLY,
                       run_unit, FC_WRITE_MULTI, run_start, run_count,
                       '0, '0, 1'b1);
    endtask

    // Works out the replies caused by one accepted request item.
    task automatic serve_request(input request_t r, input logic last);
        int unsigned start;
        int unsigned cnt;
        int unsigned pairs;
        int unsigned ia;
        int unsigned ib;
        logic [15:0] wa;
        logic [15:0] wb;
        start = r.start_address;
        cnt   = r.count_or_value;
        if (run_open) begin
            absorb_run_word(r.data_word, last);
            return;
        end
        if (r.protocol_id != '0 || r.length_field < FRAME_LEN_MIN ||
            r.length_field > FRAME_LEN_MAX) begin
            push_reply(STATUS_DROPPED, EXC_NONE, r.transaction_id, LEN_DROPPED,
                       r.unit_id, r.function_code, '0, '0, '0, '0, 1'b1);
            return;
        end
        case (r.function_code)
            FC_READ_HOLDING, FC_READ_INPUT: begin
                if (r.count_or_value >= READ_COUNT_LIMIT)
                    push_exception(EXC_ILLEGAL_VALUE, r.transaction_id, r.unit_id,
                                   r.function_code);
                else if (start + cnt > NUM_REGS)
                    push_exception(EXC_ILLEGAL_ADDRESS, r.transaction_id, r.unit_id,
                                   r.function_code);
                else begin
                    pairs = (cnt + 1) / 2;
                    if (pairs == 0)
                        pairs = 1;
                    for (int unsigned k = 0; k < pairs; k++) begin
                        ia = 2 * k;
                        ib = 2 * k + 1;
                        wa = (ia < cnt && start + ia < NUM_REGS) ?
                             holding_regs[start + ia] : '0;
                        wb = (ib < cnt && start + ib < NUM_REGS) ?
                             holding_regs[start + ib] : '0;
                        push_reply(STATUS_NORMAL, EXC_NONE, r.transaction_id,
                                   8'(LEN_READ_BASE + 2 * cnt), r.unit_id,
                                   r.function_code, 16'(2 * cnt), '0, wa, wb,
                                   k + 1 == pairs);
                    end
                end
            end
            FC_WRITE_SINGLE: begin
                if (start >= NUM_REGS)
                    push_exception(EXC_ILLEGAL_ADDRESS, r.transaction_id, r.unit_id,
                                   r.function_code);
                else begin
                    holding_regs[start] = r.count_or_value;
                    push_reply(STATUS_NORMAL, EXC_NONE, r.transaction_id,
                               LEN_WRITE_REPLY, r.unit_id, r.function_code,
                               r.start_address, r.count_or_value, '0, '0, 1'b1);
                end
            end
            FC_WRITE_MULTI: begin
                run_transaction = r.transaction_id;
                run_unit        = r.unit_id;
                run_start       = r.start_address;
                run_count       = r.count_or_value;
                run_words       = '0;
                if (int'(r.byte_count) != 2 * cnt)
                    run_fault = {1'b0, EXC_DEVICE_FAILURE} + 3'd1;
                else if (start + cnt > NUM_REGS)
                    run_fault = {1'b0, EXC_ILLEGAL_ADDRESS} + 3'd1;
                else
                    run_fault = RUN_EXC_NONE;
                run_open = 1'b1;
                absorb_run_word(r.data_word, last);
            end
            default: begin
                push_exception(EXC_ILLEGAL_FUNCTION, r.transaction_id, r.unit_id,
                               r.function_code);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------------

    // Sends one request item and predicts its replies once it is taken.
    task automatic send_request(input request_t r, input logic last);
        int gap;
        gap = sender_pauses ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 29) == 0)
            sender_pauses = !sender_pauses;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        requests_sent++;
        serve_request(r, last);
    endtask

    // A well-formed header with random echo fields and data word.
    function automatic request_t make_request(input logic [7:0] fn,
                                              input logic [15:0] start,
                                              input logic [15:0] cnt,
                                              input logic [7:0] bc);
        request_t r;
        r.transaction_id = 16'($urandom);
        r.protocol_id    = '0;
        r.length_field   = 16'($urandom_range(FRAME_LEN_MIN, FRAME_LEN_MAX));
        r.unit_id        = 8'($urandom);
        r.function_code  = fn;
        r.start_address  = start;
        r.count_or_value = cnt;
        r.byte_count     = bc;
        r.data_word      = 16'($urandom);
        return r;
    endfunction

    function automatic request_t random_request();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return request_t'(raw[S_TDATA_W-1:0]);
    endfunction

    // Opening item followed by further data items; the final one is last.
    task automatic send_write_run(input request_t head, input int words);
        send_request(head, words <= 1);
        for (int i = 2; i <= words; i++)
            send_request(random_request(), i == words);
    endtask

    // ------------------------------------------------------------------------
    // Reply checking
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Sink pacing: a fresh stall is drawn for every reply.
    initial begin
        int stall;
        forever begin
            stall = sink_pauses ? $urandom_range(0, 19) : 0;
            if ($urandom_range(0, 24) == 0)
                sink_pauses = !sink_pauses;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // Each accepted reply is compared with the oldest awaited one.
    always @(posedge aclk) begin
        reply_t         got;
        awaited_reply_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = reply_t'(m_tdata[REPLY_W-1:0]);
            if (awaited_replies.size() == 0) begin
                $error("reply with no request pending: %0h", m_tdata);
                error_count++;
            end else begin
                want = awaited_replies.pop_front();
                check_field("status", want.body.status, got.status);
                check_field("exception_code", want.body.exception_code,
                            got.exception_code);
                check_field("reply_transaction", want.body.reply_transaction,
                            got.reply_transaction);
                check_field("reply_length", want.body.reply_length,
                            got.reply_length);
                check_field("reply_unit", want.body.reply_unit, got.reply_unit);
                check_field("reply_function", want.body.reply_function,
                            got.reply_function);
                check_field("echo_first", want.body.echo_first, got.echo_first);
                check_field("echo_second", want.body.echo_second, got.echo_second);
                check_field("read_word_a", want.body.read_word_a, got.read_word_a);
                check_field("read_word_b", want.body.read_word_b, got.read_word_b);
                check_field("last_result", want.last, m_tlast);
            end
        end
    end

    // Watchdog: ends the run when neither side has moved for too long.
    always @(posedge aclk) begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
            (m_tvalid === 1'b1 && m_tready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Frames with a non-zero protocol id or a length out of range.
    task automatic test_dropped_frames();
        request_t r;
        r = make_request(FC_READ_HOLDING, 16'd0, 16'd1, 8'd0);
        r.protocol_id = 16'hFFFF;
        send_request(r, 1'b1);
        r = make_request(FC_WRITE_SINGLE, 16'd5, 16'h1234, 8'd0);
        r.length_field = FRAME_LEN_MIN - 16'd1;
        send_request(r, 1'b0);
        // A dropped multi-write must not open a run.
        r = make_request(FC_WRITE_MULTI, 16'd0, 16'd1, 8'd2);
        r.length_field = FRAME_LEN_MAX + 16'd1;
        send_request(r, 1'b0);
        r = make_request(FC_READ_INPUT, 16'd0, 16'd1, 8'd0);
        r.length_field = 16'hFFFF;
        send_request(r, 1'b1);
    endtask

    // Single writes at both ends of the file and just beyond it.
    task automatic test_single_writes();
        request_t r;
        r = make_request(FC_WRITE_SINGLE, 16'd0, 16'hFFFF, 8'd0);
        r.length_field = FRAME_LEN_MIN;
        send_request(r, 1'b1);
        r = make_request(FC_WRITE_SINGLE, 16'(NUM_REGS - 1), 16'h8001, 8'hFF);
        r.length_field = FRAME_LEN_MAX;
        send_request(r, 1'b0);
        send_request(make_request(FC_WRITE_SINGLE, 16'(NUM_REGS), 16'h5A5A, 8'd0),
                     1'b1);
        send_request(make_request(FC_WRITE_SINGLE, 16'hFFFF, 16'h0000, 8'd0), 1'b1);
    endtask

    // Reads of zero, odd, even and the largest counts, plus the limits.
    task automatic test_reads();
        send_request(make_request(FC_READ_HOLDING, 16'd0, 16'd0, 8'd0), 1'b1);
        send_request(make_request(FC_READ_INPUT, 16'd0, 16'd2, 8'd0), 1'b0);
        send_request(make_request(FC_READ_HOLDING, 16'(NUM_REGS - 1), 16'd1, 8'd0),
                     1'b1);
        send_request(make_request(FC_READ_INPUT, 16'd0, READ_COUNT_LIMIT - 16'd1,
                                  8'd0), 1'b1);
        send_request(make_request(FC_READ_HOLDING, 16'd0, READ_COUNT_LIMIT, 8'd0),
                     1'b1);
        send_request(make_request(FC_READ_HOLDING, 16'(NUM_REGS - 2), 16'd3, 8'd0),
                     1'b1);
        send_request(make_request(FC_READ_INPUT, 16'd0, 16'hFFFF, 8'd0), 1'b1);
    endtask

    // Multi-write runs: complete, short, overlong, a zero count and the two faults.
    task automatic test_multi_writes();
        send_write_run(make_request(FC_WRITE_MULTI, 16'd10, 16'd3, 8'd6), 3);
        send_request(make_request(FC_READ_HOLDING, 16'd9, 16'd5, 8'd0), 1'b1);
        send_write_run(make_request(FC_WRITE_MULTI, 16'd20, 16'd3, 8'd6), 2);
        send_write_run(make_request(FC_WRITE_MULTI, 16'(NUM_REGS - 1), 16'd1,
                                    8'd2), 3);
        send_write_run(make_request(FC_WRITE_MULTI, 16'd30, 16'd2, 8'd5), 2);
        send_write_run(make_request(FC_WRITE_MULTI, 16'(NUM_REGS - 1), 16'd2,
                                    8'd4), 1);
        send_write_run(make_request(FC_WRITE_MULTI, 16'd0, 16'd0, 8'd0), 1);
        send_request(make_request(FC_READ_INPUT, 16'd18, 16'd4, 8'd0), 1'b1);
    endtask

    // Function codes that the server does not offer.
    task automatic test_other_functions();
        send_request(make_request(FC_LOWEST, 16'd0, 16'd1, 8'd0), 1'b1);
        send_request(make_request(FC_HIGHEST, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0);
    endtask

    function automatic logic [15:0] pick_address();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 16'($urandom_range(0, 31));
        else if (sel < 7)
            return 16'($urandom_range(NUM_REGS - 16, NUM_REGS - 1));
        else if (sel < 9)
            return 16'($urandom_range(0, NUM_REGS - 1));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_read_count();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 16)
            return 16'($urandom_range(0, 12));
        else if (sel < 19)
            return 16'($urandom_range(13, READ_COUNT_LIMIT - 1));
        return 16'($urandom_range(READ_COUNT_LIMIT, 16'hFFFF));
    endfunction

    // Mostly well-formed traffic with random content, some noise on top.
    task automatic test_random_traffic();
        request_t    r;
        int          sel;
        int          words;
        logic [15:0] cnt;
        logic [7:0]  fn;
        while (requests_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                send_request(random_request(), 1'($urandom));
            end else if (sel < 30) begin
                fn = $urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT;
                send_request(make_request(fn, pick_address(), pick_read_count(),
                                          8'($urandom)), 1'($urandom));
            end else if (sel < 50) begin
                send_request(make_request(FC_WRITE_SINGLE, pick_address(),
                                          16'($urandom), 8'($urandom)), 1'($urandom));
            end else if (sel < 82) begin
                sel = $urandom_range(0, 19);
                cnt = (sel < 17) ? 16'($urandom_range(0, 8)) :
                      (sel < 19) ? 16'($urandom_range(9, 40)) : 16'($urandom);
                r = make_request(FC_WRITE_MULTI, pick_address(), cnt,
                                 8'(2 * cnt));
                if ($urandom_range(0, 99) < 15)
                    r.byte_count = 8'($urandom);
                sel = $urandom_range(0, 9);
                if (cnt > 40)
                    words = $urandom_range(1, 4);
                else if (sel < 7)
                    words = cnt;
                else if (sel < 9)
                    words = cnt - 1;
                else
                    words = cnt + $urandom_range(1, 3);
                if (words < 1)
                    words = 1;
                send_write_run(r, words);
            end else if (sel < 90) begin
                do fn = 8'($urandom);
                while (fn == FC_READ_HOLDING || fn == FC_READ_INPUT ||
                       fn == FC_WRITE_SINGLE || fn == FC_WRITE_MULTI);
                send_request(make_request(fn, 16'($urandom), 16'($urandom),
                                          8'($urandom)), 1'($urandom));
            end else begin
                r = random_request();
                if ($urandom_range(0, 1))
                    r.protocol_id = 16'($urandom_range(1, 16'hFFFF));
                else if ($urandom_range(0, 1))
                    r.length_field = 16'($urandom_range(0, FRAME_LEN_MIN - 1));
                else
                    r.length_field = 16'($urandom_range(FRAME_LEN_MAX + 1, 16'hFFFF));
                send_request(r, 1'($urandom));
            end
        end
        // Noise may have opened a run; close it before the end.
        while (run_open)
            send_request(random_request(), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        run_open        = 1'b0;
        run_transaction = '0;
        run_unit        = '0;
        run_start       = '0;
        run_count       = '0;
        run_words       = '0;
        run_fault       = RUN_EXC_NONE;
        for (int i = 0; i < NUM_REGS; i++)
            holding_regs[i] = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_dropped_frames();
        test_single_writes();
        test_reads();
        test_multi_writes();
        test_other_functions();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && awaited_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
